>>> src/sor_pkg.sv
// Package for the sample ring: defaults, codes and the drain sequencer state type.
`timescale 1ns / 1ps
package sor_pkg;

	localparam int RING_DEPTH_DEF  = 256;
	localparam int SAMPLE_BITS_DEF = 64;
	localparam int MAX_DRAIN_DEF   = 63;

	localparam int SAMPLE_W = 64;
	localparam int CNT_W    = 6;
	localparam int CAP_W    = 16;
	localparam int PLEN_W   = 2;
	localparam int BYTE_W   = 8;

	localparam logic [CAP_W-1:0] CAP_RESET = 16'd1024;
	// fixed reply overhead in bytes
	localparam int HDR_BYTES = 10;

	// parameter byte decode
	localparam logic [BYTE_W-1:0] ARRAY_MASK   = 8'hF0;
	localparam logic [BYTE_W-1:0] ARRAY_PREFIX = 8'h90;
	localparam logic [BYTE_W-1:0] COUNT_MASK   = 8'h7F;
	localparam logic [BYTE_W-1:0] BARE_MASK    = 8'h80;

	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_OVERRUN = 2'd1;
	localparam logic [1:0] STATUS_CAP_ERR = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COUNT,
		ST_HEAD,
		ST_DRAIN
	} sor_state_t;

endpackage

>>> src/sor_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sor_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds while re is low
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/sample_ring_overwrite_drain_top.sv
// Sample ring FIFO with overwrite of the oldest sample and a counted drain.
//
//  channel  dir  handshake          payload
//  in       in   in_valid/in_stall  op, sample_in, param_length, param_first_byte,
//                                   param_second_byte
//  out      out  out_valid/out_stall is_sample, status, count, sample_out, last
//  cfg      in   cfg_we             cfg_wdata (reply byte budget)
//
// A push is one RAM write plus pointer update. A drain latches its limit,
// counts in ST_COUNT, loads the header, then, if out_stall allows, one sample per
// cycle from the RAM read port (registered read, next address issued as each
// word is loaded). in_stall is high from drain accept until its last word is
// loaded. out_stall freezes the output register and the sequencer with it. Reset
// clears pointers and flag, sets cap_q to CAP_RESET; the sample RAM is not cleared.
`timescale 1ns / 1ps
module sample_ring_overwrite_drain_top
	import sor_pkg::*;
#(
	parameter int RING_DEPTH  = RING_DEPTH_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int MAX_DRAIN   = MAX_DRAIN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic [SAMPLE_W-1:0] sample_in,
	input  logic [PLEN_W-1:0]   param_length,
	input  logic [BYTE_W-1:0]   param_first_byte,
	input  logic [BYTE_W-1:0]   param_second_byte,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                is_sample,
	output logic [1:0]          status,
	output logic [CNT_W-1:0]    count,
	output logic [SAMPLE_W-1:0] sample_out,
	output logic                last,
	input  logic                cfg_we,
	input  logic [CAP_W-1:0]    cfg_wdata
);

	localparam int IW           = $clog2(RING_DEPTH);
	localparam int CMPW         = (IW > CNT_W) ? IW : CNT_W;
	localparam int SAMPLE_BYTES = (SAMPLE_BITS + 7) / 8;
	localparam logic [IW-1:0]    LAST_IDX  = IW'(RING_DEPTH - 1);
	localparam logic [CNT_W-1:0] MAX_LIMIT = CNT_W'(MAX_DRAIN);

	sor_state_t state_q, state_d;

	logic [IW-1:0]          wr_idx_q, rd_idx_q;
	logic                   overrun_q;
	logic [CAP_W-1:0]       cap_q;
	logic [CNT_W-1:0]       limit_q, cnt_q, remain_q;
	logic                   ovr_seen_q;

	logic                   out_valid_q;
	logic                   is_sample_q, last_q;
	logic [1:0]             status_q;
	logic [CNT_W-1:0]       count_q;
	logic [SAMPLE_BITS-1:0] sample_q;

	logic                   accept, push, drain;
	logic                   out_free;
	logic [IW-1:0]          wr_next, rd_next;
	logic [IW-1:0]          fill;
	logic [CNT_W-1:0]       cnt_min;
	logic [CNT_W-1:0]       limit_dec;
	logic [CAP_W-1:0]       need;
	logic                   cap_fail;

	logic                   ram_re;
	logic [IW-1:0]          ram_raddr;
	logic [SAMPLE_BITS-1:0] ram_rdata;
	logic                   load_hdr, load_smp, hdr_done;

	function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
		return (idx == LAST_IDX) ? '0 : idx + IW'(1);
	endfunction

	assign accept   = in_valid && !in_stall;
	assign push     = accept && (op == OP_PUSH);
	assign drain    = accept && (op == OP_DRAIN);
	assign out_free = !out_valid_q || !out_stall;
	assign wr_next  = ring_next(wr_idx_q);
	assign rd_next  = ring_next(rd_idx_q);

	// request limit from the parameter bytes
	always_comb begin
		logic [BYTE_W-1:0] lim;
		lim = 8'd1;
		if (param_length != '0) begin
			if (param_length[1] && ((param_first_byte & ARRAY_MASK) == ARRAY_PREFIX)) begin
				lim = param_second_byte & COUNT_MASK;
			end else if ((param_first_byte & BARE_MASK) == '0) begin
				lim = param_first_byte;
			end
		end
		if (lim == '0) begin
			lim = 8'd1;
		end
		if (lim > BYTE_W'(MAX_DRAIN)) begin
			limit_dec = MAX_LIMIT;
		end else begin
			limit_dec = lim[CNT_W-1:0];
		end
	end

	// fill level and sample count
	always_comb begin
		logic [IW:0] diff;
		diff = {1'b0, wr_idx_q} + (IW+1)'(RING_DEPTH) - {1'b0, rd_idx_q};
		if (wr_idx_q >= rd_idx_q) begin
			fill = wr_idx_q - rd_idx_q;
		end else begin
			fill = diff[IW-1:0];
		end
		if (CMPW'(fill) < CMPW'(limit_q)) begin
			cnt_min = CNT_W'(fill);
		end else begin
			cnt_min = limit_q;
		end
	end

	assign need     = CAP_W'(cnt_q) * CAP_W'(SAMPLE_BYTES) + CAP_W'(HDR_BYTES);
	assign cap_fail = need > cap_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (drain) begin
					state_d = ST_COUNT;
				end
			end
			ST_COUNT: begin
				state_d = ST_HEAD;
			end
			ST_HEAD: begin
				if (out_free) begin
					state_d = (cap_fail || cnt_q == '0) ? ST_IDLE : ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (out_free && remain_q == CNT_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = 1'b1;
		load_hdr  = 1'b0;
		load_smp  = 1'b0;
		hdr_done  = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = rd_idx_q;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_COUNT: begin
			end
			ST_HEAD: begin
				if (out_free) begin
					load_hdr = 1'b1;
					hdr_done = !cap_fail && cnt_q != '0;
					ram_re   = hdr_done;
				end
			end
			ST_DRAIN: begin
				if (out_free) begin
					load_smp  = 1'b1;
					// prefetch the following word while this one is loaded
					ram_re    = remain_q != CNT_W'(1);
					ram_raddr = rd_next;
				end
			end
			default: begin
			end
		endcase
	end

	sor_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(RING_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (push),
		.waddr(wr_idx_q),
		.wdata(sample_in[SAMPLE_BITS-1:0]),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			overrun_q   <= 1'b0;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
			remain_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (push) begin
				wr_idx_q <= wr_next;
				// full ring: drop the oldest word
				if (wr_next == rd_idx_q) begin
					rd_idx_q  <= rd_next;
					overrun_q <= 1'b1;
				end
			end else if (drain) begin
				overrun_q <= 1'b0;
			end else if (load_smp) begin
				rd_idx_q <= rd_next;
			end
			if (hdr_done) begin
				remain_q <= cnt_q;
			end else if (load_smp) begin
				remain_q <= remain_q - CNT_W'(1);
			end
			if (load_hdr || load_smp) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			limit_q    <= limit_dec;
			ovr_seen_q <= overrun_q;
		end
		if (state_q == ST_COUNT) begin
			cnt_q <= cnt_min;
		end
		if (load_hdr) begin
			is_sample_q <= 1'b0;
			sample_q    <= '0;
			if (cap_fail) begin
				status_q <= STATUS_CAP_ERR;
				count_q  <= '0;
				last_q   <= 1'b1;
			end else begin
				status_q <= ovr_seen_q ? STATUS_OVERRUN : STATUS_OK;
				count_q  <= cnt_q;
				last_q   <= cnt_q == '0;
			end
		end else if (load_smp) begin
			is_sample_q <= 1'b1;
			status_q    <= STATUS_OK;
			count_q     <= '0;
			sample_q    <= ram_rdata;
			last_q      <= remain_q == CNT_W'(1);
		end
	end

	assign out_valid  = out_valid_q;
	assign is_sample  = is_sample_q;
	assign status     = status_q;
	assign count      = count_q;
	assign sample_out = SAMPLE_W'(sample_q);
	assign last       = last_q;

endmodule
